// ===== sv/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg: shared types for linear blend vertex skinning
// Item structs, palette matrix layout and fixed arithmetic widths.
// ----------------------------------------------------------------------------
package lbs_pkg;

  // operation codes of an input item
  localparam logic OP_SKIN = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // words of one bone matrix: four rows of three columns
  localparam int MAT_WORDS = 12;

  // Q1.15 one and blend weight width (implicit last weight may go negative)
  localparam int WW = 19;
  localparam logic signed [WW-1:0] ONE_Q15 = 19'sd32768;

  typedef logic signed [31:0] lbs_pos_t;
  typedef logic signed [15:0] lbs_nrm_t;
  typedef logic signed [WW-1:0] lbs_wgt_t;
  typedef logic [MAT_WORDS-1:0][31:0] lbs_mat_t;

  // per-lane weighted results: position mod 2^63, exact normal term
  typedef logic [62:0] lbs_pacc_t;
  typedef logic signed [52:0] lbs_nacc_t;

  typedef struct packed {
    logic        operation;
    lbs_pos_t    pos_x;
    lbs_pos_t    pos_y;
    lbs_pos_t    pos_z;
    lbs_nrm_t    nrm_x;
    lbs_nrm_t    nrm_y;
    lbs_nrm_t    nrm_z;
    logic [31:0] tex_uv;
    logic [23:0] bone_ids;
    logic [47:0] weights;
    logic [41:0] load_word;
    logic        last_vertex;
  } lbs_in_t;

  typedef struct packed {
    lbs_pos_t    out_pos_x;
    lbs_pos_t    out_pos_y;
    lbs_pos_t    out_pos_z;
    lbs_nrm_t    out_nrm_x;
    lbs_nrm_t    out_nrm_y;
    lbs_nrm_t    out_nrm_z;
    logic [31:0] out_tex_uv;
    logic        out_last;
  } lbs_out_t;

endpackage

// ===== sv/lbs_palette.sv =====
// ----------------------------------------------------------------------------
// lbs_palette: bone matrix palette
// One copy per influence lane, each split into twelve word memories so a
// lane reads a whole matrix per cycle; loads write all copies.
// ----------------------------------------------------------------------------
module lbs_palette #(
  parameter int NUM_BONES = 64,
  parameter int LANES     = 4,
  parameter int AW        = 6
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_bone,
  input  logic [3:0]            wr_word,
  input  logic [31:0]           wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_bone [LANES],
  output lbs_pkg::lbs_mat_t     rd_mat  [LANES]
);
  import lbs_pkg::*;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    for (genvar k = 0; k < MAT_WORDS; k++) begin : g_word
      logic [31:0] mem [NUM_BONES];
      logic [31:0] rd_r;

      // write the matching word, read on stage advance
      always_ff @(posedge clk) begin
        if (wr_en && wr_word == 4'(k)) begin
          mem[wr_bone] <= wr_data;
        end
        if (rd_en) begin
          rd_r <= mem[rd_bone[l]];
        end
      end

      assign rd_mat[l][k] = rd_r;
    end
  end

endmodule

// ===== sv/lbs_lane.sv =====
// ----------------------------------------------------------------------------
// lbs_lane: one bone influence
// Transforms position and normal by one matrix and scales by its weight,
// over four register stages.
// ----------------------------------------------------------------------------
module lbs_lane (
  input  logic               clk,
  input  logic [3:0]         en,
  input  lbs_pkg::lbs_mat_t  mat,
  input  lbs_pkg::lbs_pos_t  pos   [3],
  input  lbs_pkg::lbs_nrm_t  nrm   [3],
  input  lbs_pkg::lbs_wgt_t  wgt,
  output lbs_pkg::lbs_pacc_t pacc  [3],
  output lbs_pkg::lbs_nacc_t nacc  [3]
);
  import lbs_pkg::*;

  logic signed [63:0] pp_r [3][3];
  logic signed [47:0] np_r [3][3];
  lbs_pos_t           m3_r [3];
  lbs_wgt_t           w2_r, w3_r;
  logic [62:0]        t_r  [3];
  logic signed [33:0] tn_r [3];
  logic signed [51:0] pl_r [3];
  logic signed [50:0] ph_r [3];
  logic signed [52:0] nw_r [3];
  lbs_pacc_t          pacc_r [3];
  lbs_nacc_t          nacc_r [3];

  // multiply position and normal components by matrix entries
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          pp_r[c][r] <= pos[r] * $signed(mat[r*3+c]);
          np_r[c][r] <= nrm[r] * $signed(mat[r*3+c]);
        end
        m3_r[c] <= $signed(mat[9+c]);
      end
      w2_r <= wgt;
    end
  end

  // sum rows, add translation, floor the normal term
  always_ff @(posedge clk) begin
    logic signed [63:0] ts;
    logic signed [49:0] ns;
    if (en[1]) begin
      for (int c = 0; c < 3; c++) begin
        ts = pp_r[c][0] + pp_r[c][1] + pp_r[c][2] + (64'(m3_r[c]) <<< 16);
        ns = np_r[c][0] + np_r[c][1] + np_r[c][2];
        t_r[c]  <= ts[62:0];
        tn_r[c] <= 34'(ns >>> 16);
      end
      w3_r <= w2_r;
    end
  end

  // apply weight; position split into low and high partial products
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int c = 0; c < 3; c++) begin
        pl_r[c] <= w3_r * $signed({1'b0, t_r[c][31:0]});
        ph_r[c] <= w3_r * $signed({1'b0, t_r[c][62:32]});
        nw_r[c] <= w3_r * tn_r[c];
      end
    end
  end

  // combine partial products modulo 2^63
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int c = 0; c < 3; c++) begin
        pacc_r[c] <= 63'(pl_r[c]) + {ph_r[c][30:0], 32'b0};
        nacc_r[c] <= nw_r[c];
      end
    end
  end

  assign pacc = pacc_r;
  assign nacc = nacc_r;

endmodule

// ===== sv/linear_blend_vertex_skinning.sv =====
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning: skinning pipeline, up to four bones
// Palette read, per-bone transform lanes, weighted blend and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one item a cycle. A load item whose slot is in
//   range writes one palette word at its accept edge and yields no result; a skin
//   item yields one result on out_valid/out_ready. cfg_we writes the influence count.
//   Throughput: one item per clock cycle, set by the palette, which keeps one
//   copy per influence lane with a full-matrix read port each.
//   Pipeline: a skin item crosses six register stages (palette read, multiply,
//   row sum, weight multiply, combine, blend) before it shows on out_data.
//   A load is visible to the next item accepted.
//   Reset empties the pipeline and sets the influence count to one; the
//   palette holds no defined value until words are loaded.
//   When the receiver stalls, the output item holds and each stage holds
//   only if the stage ahead is full, so bubbles close up before in_ready
//   drops.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning #(
  parameter int NUM_BONES      = 64,
  parameter int MAX_INFLUENCES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lbs_pkg::lbs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lbs_pkg::lbs_out_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_wdata
);
  import lbs_pkg::*;

  localparam int AW        = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;
  localparam int LANES     = MAX_INFLUENCES;
  localparam int PAL_WORDS = NUM_BONES * MAT_WORDS;
  localparam int NSTG      = 6;

  logic [2:0]      cnt_r;
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  // hold influence count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd1;
    end else if (cfg_we) begin
      cnt_r <= cfg_wdata;
    end
  end

  // advance each stage when it is empty or the one ahead moves
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || out_ready;
    for (int k = NSTG-2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid && in_data.operation == OP_SKIN;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // decode load slot: bone = slot/12 through reciprocal, word = remainder
  logic [9:0]    slot;
  logic [19:0]   slot_q;
  logic [10:0]   wr_bone_full;
  logic [14:0]   bone_x12;
  logic [3:0]    wr_word;
  logic          wr_en;
  logic [AW-1:0] wr_bone;

  always_comb begin
    slot         = in_data.load_word[41:32];
    slot_q       = 20'(slot) * 20'd683;
    wr_bone_full = 11'(slot_q >> 13);
    bone_x12     = 15'(wr_bone_full) * 15'd12;
    wr_word      = 4'(15'(slot) - bone_x12);
    wr_bone      = AW'(wr_bone_full);
    wr_en        = in_valid && in_ready && in_data.operation == OP_LOAD &&
                   32'(slot) < 32'(PAL_WORDS);
  end

  // clamp bone indices
  logic [AW-1:0] rd_bone [LANES];

  always_comb begin
    logic [5:0] id;
    for (int l = 0; l < LANES; l++) begin
      id = in_data.bone_ids[6*l +: 6];
      if (32'(id) >= NUM_BONES) begin
        rd_bone[l] = AW'(NUM_BONES - 1);
      end else begin
        rd_bone[l] = AW'(id);
      end
    end
  end

  // decode blend weights for the active mode
  logic [2:0] eff;
  lbs_wgt_t   wa, wb, wc;
  lbs_wgt_t   w_dec [4];

  always_comb begin
    eff = cnt_r;
    if (eff == 3'd0) eff = 3'd1;
    if (eff > 3'd4) eff = 3'd4;
    if (eff > 3'(MAX_INFLUENCES)) eff = 3'(MAX_INFLUENCES);
    wa = $signed({3'b0, in_data.weights[15:0]});
    wb = $signed({3'b0, in_data.weights[31:16]});
    wc = $signed({3'b0, in_data.weights[47:32]});
    for (int b = 0; b < 4; b++) begin
      w_dec[b] = '0;
    end
    unique case (eff)
      3'd2: begin
        w_dec[0] = ONE_Q15 - wa;
        w_dec[1] = wa;
      end
      3'd3: begin
        w_dec[0] = wa;
        w_dec[1] = wb;
        w_dec[2] = ONE_Q15 - wa - wb;
      end
      3'd4: begin
        w_dec[0] = wa;
        w_dec[1] = wb;
        w_dec[2] = wc;
        w_dec[3] = ONE_Q15 - wa - wb - wc;
      end
      default: begin
        w_dec[0] = ONE_Q15;
      end
    endcase
  end

  // stage 1: palette read alongside vertex fields
  lbs_mat_t    mat [LANES];
  lbs_pos_t    pos_r [3];
  lbs_nrm_t    nrm_r [3];
  lbs_wgt_t    w_r [LANES];
  logic [31:0] tex_r  [NSTG-1];
  logic        last_r [NSTG-1];

  lbs_palette #(
    .NUM_BONES (NUM_BONES),
    .LANES     (LANES),
    .AW        (AW)
  ) u_palette (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_bone (wr_bone),
    .wr_word (wr_word),
    .wr_data (in_data.load_word[31:0]),
    .rd_en   (en[0]),
    .rd_bone (rd_bone),
    .rd_mat  (mat)
  );

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pos_r[0] <= in_data.pos_x;
      pos_r[1] <= in_data.pos_y;
      pos_r[2] <= in_data.pos_z;
      nrm_r[0] <= in_data.nrm_x;
      nrm_r[1] <= in_data.nrm_y;
      nrm_r[2] <= in_data.nrm_z;
      for (int l = 0; l < LANES; l++) begin
        w_r[l] <= w_dec[l];
      end
      tex_r[0]  <= in_data.tex_uv;
      last_r[0] <= in_data.last_vertex;
    end
  end

  // carry pass-through fields with the item
  always_ff @(posedge clk) begin
    for (int k = 1; k < NSTG-1; k++) begin
      if (en[k]) begin
        tex_r[k]  <= tex_r[k-1];
        last_r[k] <= last_r[k-1];
      end
    end
  end

  // stages 2 to 5: per-bone lanes
  lbs_pacc_t pacc [LANES][3];
  lbs_nacc_t nacc [LANES][3];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    lbs_lane u_lane (
      .clk  (clk),
      .en   (en[4:1]),
      .mat  (mat[l]),
      .pos  (pos_r),
      .nrm  (nrm_r),
      .wgt  (w_r[l]),
      .pacc (pacc[l]),
      .nacc (nacc[l])
    );
  end

  // stage 6: blend lanes, wrap position, saturate normal
  lbs_out_t out_r;
  lbs_pos_t pres [3];
  lbs_nrm_t nres [3];

  always_comb begin
    logic [62:0]        psum;
    logic signed [54:0] nsum;
    logic signed [54:0] nsh;
    for (int c = 0; c < 3; c++) begin
      psum = '0;
      nsum = '0;
      for (int l = 0; l < LANES; l++) begin
        psum = psum + pacc[l][c];
        nsum = nsum + 55'(nacc[l][c]);
      end
      pres[c] = $signed(psum[62:31]);
      nsh = nsum >>> 15;
      if (nsh > 55'sd32767) begin
        nres[c] = 16'sh7fff;
      end else if (nsh < -55'sd32768) begin
        nres[c] = 16'sh8000;
      end else begin
        nres[c] = nsh[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      out_r.out_pos_x  <= pres[0];
      out_r.out_pos_y  <= pres[1];
      out_r.out_pos_z  <= pres[2];
      out_r.out_nrm_x  <= nres[0];
      out_r.out_nrm_y  <= nres[1];
      out_r.out_nrm_z  <= nres[2];
      out_r.out_tex_uv <= tex_r[NSTG-2];
      out_r.out_last   <= last_r[NSTG-2];
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_data  = out_r;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for linear_blend_vertex_skinning
// Loads bone palettes, streams skin items under random stalls on both sides
// and checks every result against a blended-transform predictor.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbs_pkg::*;

  localparam int NBONES    = 64;
  localparam int PAL_SIZE  = NBONES * MAT_WORDS;
  localparam int WDOG_MAX  = 20000;
  localparam int DRAIN_CYC = 20;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  lbs_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lbs_out_t out_data;
  logic     cfg_we = 1'b0;
  logic [2:0] cfg_wdata = 3'd0;

  linear_blend_vertex_skinning dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [31:0] bone_words [PAL_SIZE];
  bit          bone_loaded [NBONES];
  logic [2:0]  blend_count;

  lbs_in_t  pending_items [$];
  lbs_out_t skinned_expect [$];
  int       fail_count = 0;
  bit       stim_done = 1'b0;
  int       idle_cycles = 0;
  bit       hold_off = 1'b0;

  function automatic longint floor_div(longint x, int s);
    return x >>> s;
  endfunction

  // work out the skinned vertex for one item
  function automatic lbs_out_t skin_vertex(lbs_in_t it);
    lbs_out_t r;
    longint p [3];
    longint n [3];
    longint w [4];
    int     ids [4];
    int     cnt;
    longint lastw;
    logic [63:0] pacc;
    logic [63:0] t;
    longint nacc, nt, ns, m;
    for (int c = 0; c < 3; c++) begin
      p[c] = (c == 0) ? it.pos_x : (c == 1) ? it.pos_y : it.pos_z;
      n[c] = (c == 0) ? it.nrm_x : (c == 1) ? it.nrm_y : it.nrm_z;
    end
    for (int b = 0; b < 4; b++) begin
      ids[b] = it.bone_ids[6*b +: 6];
      if (ids[b] >= NBONES) ids[b] = NBONES - 1;
    end
    cnt = blend_count;
    if (cnt < 1) cnt = 1;
    if (cnt > 4) cnt = 4;
    w[0] = 32768; w[1] = 0; w[2] = 0; w[3] = 0;
    if (cnt == 2) begin
      w[1] = it.weights[15:0];
      w[0] = 32768 - w[1];
    end else if (cnt >= 3) begin
      lastw = 32768;
      for (int b = 0; b + 1 < cnt; b++) begin
        w[b] = it.weights[16*b +: 16];
        lastw -= w[b];
      end
      w[cnt-1] = lastw;
    end
    for (int c = 0; c < 3; c++) begin
      pacc = '0;
      nacc = 0;
      for (int b = 0; b < cnt; b++) begin
        m = $signed(bone_words[ids[b]*12 + 9 + c]);
        t = m << 16;
        nt = 0;
        for (int rr = 0; rr < 3; rr++) begin
          m = $signed(bone_words[ids[b]*12 + rr*3 + c]);
          t += p[rr] * m;
          nt += n[rr] * m;
        end
        pacc += w[b] * t;
        nacc += w[b] * floor_div(nt, 16);
      end
      ns = floor_div(nacc, 15);
      if (ns > 32767) ns = 32767;
      if (ns < -32768) ns = -32768;
      case (c)
        0: begin r.out_pos_x = pacc[62:31]; r.out_nrm_x = ns[15:0]; end
        1: begin r.out_pos_y = pacc[62:31]; r.out_nrm_y = ns[15:0]; end
        default: begin r.out_pos_z = pacc[62:31]; r.out_nrm_z = ns[15:0]; end
      endcase
    end
    r.out_tex_uv = it.tex_uv;
    r.out_last = it.last_vertex;
    return r;
  endfunction

  function automatic lbs_in_t load_item(int slot, logic [31:0] val);
    lbs_in_t it;
    it = '0;
    it.operation = OP_LOAD;
    it.pos_x = $urandom;
    it.nrm_y = 16'($urandom);
    it.load_word = {slot[9:0], val};
    return it;
  endfunction

  // random word biased toward extremes
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0001_0000;
      3: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
      default: return $urandom;
    endcase
  endfunction

  // vertex item using loaded bones only
  function automatic lbs_in_t skin_item();
    lbs_in_t it;
    int      id;
    it = '0;
    it.operation = OP_SKIN;
    it.pos_x = rand_word(); it.pos_y = rand_word(); it.pos_z = rand_word();
    it.nrm_x = 16'($urandom); it.nrm_y = 16'($urandom); it.nrm_z = 16'($urandom);
    if ($urandom_range(0, 3) == 0) it.nrm_x = 16'h8000;
    it.tex_uv = $urandom;
    for (int b = 0; b < 4; b++) begin
      do id = $urandom_range(0, NBONES - 1); while (!bone_loaded[id]);
      it.bone_ids[6*b +: 6] = 6'(id);
    end
    it.weights = 48'({$urandom, $urandom});
    if ($urandom_range(0, 3) == 0) it.weights = {3{16'($urandom_range(0, 12000))}};
    it.last_vertex = 1'($urandom);
    it.load_word = 42'({$urandom, $urandom});
    return it;
  endfunction

  task automatic queue_bone(int id, bit ident);
    for (int k = 0; k < MAT_WORDS; k++) begin
      if (ident) pending_items.push_back(load_item(id*12 + k, (k % 4 == 0) ? 32'h1_0000 : 0));
      else pending_items.push_back(load_item(id*12 + k, rand_word()));
    end
    bone_loaded[id] = 1'b1;
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || skinned_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic set_count(logic [2:0] v);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drive items from the pending queue, with random gaps
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (in_data.operation == OP_LOAD) begin
          if (in_data.load_word[41:32] < PAL_SIZE)
            bone_words[in_data.load_word[41:32]] = in_data.load_word[31:0];
        end else begin
          skinned_expect.push_back(skin_vertex(in_data));
        end
        void'(pending_items.pop_front());
      end
      if (in_valid && !in_ready) begin
        // hold
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > ((in_valid && in_ready) ? 0 : 0)
                   && !(in_valid && !in_ready)) begin
        if (pending_items.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items[0];
          gap_left <= ($urandom_range(0, 3) == 0) ?
                      (($urandom_range(0, 15) == 0) ? $urandom_range(5, 20)
                                                    : $urandom_range(1, 2)) : 0;
        end else in_valid <= 1'b0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern plus result check
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (skinned_expect.size() == 0) begin
          $display("%0t: unexpected result %h", $realtime, out_data);
          fail_count++;
        end else begin
          if (out_data !== skinned_expect[0]) begin
            $display("%0t: mismatch expected %h actual %h", $realtime,
                     skinned_expect[0], out_data);
            fail_count++;
          end
          void'(skinned_expect.pop_front());
        end
      end
      if (hold_off) out_ready <= 1'b0;
      else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 4) == 0)
          stall_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(5, 30)
                                                     : $urandom_range(1, 2);
      end
    end
  end

  // long receiver hold-off while the sender keeps offering items
  initial begin
    wait (stim_done === 1'b0 && rst_n);
    wait (skinned_expect.size() > 3);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog on accept activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    lbs_in_t it;
    blend_count = 3'd1;
    for (int k = 0; k < PAL_SIZE; k++) bone_words[k] = '0;
    for (int k = 0; k < NBONES; k++) bone_loaded[k] = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity and random bones, extremes, last bone via all-ones ids
    queue_bone(0, 1'b1);
    queue_bone(NBONES - 1, 1'b0);
    queue_bone(5, 1'b0);
    pending_items.push_back(load_item(PAL_SIZE, 32'hDEAD_BEEF));
    pending_items.push_back(load_item(1023, 32'h1234_5678));
    wait_idle();
    for (int m = 0; m < 8; m++) begin
      blend_count = 3'(m);
      set_count(3'(m));
      for (int k = 0; k < 3; k++) begin
        it = skin_item();
        case (k)
          0: begin
            it.pos_x = 32'h7FFF_FFFF; it.pos_y = 32'h8000_0000; it.pos_z = '1;
            it.nrm_x = 16'h7FFF; it.nrm_y = 16'h8000; it.nrm_z = 16'hFFFF;
            it.weights = '1; it.bone_ids = '1; it.tex_uv = '1; it.last_vertex = 1;
          end
          1: begin it.weights = '0; it.bone_ids = {6'd5, 6'd0, 6'd63, 6'd0}; end
          default: it.weights = {16'd8192, 16'd8192, 16'd8192};
        endcase
        pending_items.push_back(it);
      end
      wait_idle();
    end

    // random phases across influence settings
    for (int ph = 0; ph < 6; ph++) begin
      logic [2:0] v;
      v = (ph == 0) ? 3'd4 : (ph == 1) ? 3'd1 : 3'($urandom_range(0, 7));
      blend_count = v;
      set_count(v);
      for (int k = 0; k < 175; k++) begin
        if ($urandom_range(0, 19) == 0)
          pending_items.push_back(load_item($urandom_range(0, PAL_SIZE - 1) & ~0
                                  | 0, rand_word()));
        else if ($urandom_range(0, 39) == 0) queue_bone($urandom_range(0, NBONES - 1), 0);
        else pending_items.push_back(skin_item());
      end
      wait_idle();
    end
    stim_done = 1'b1;
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
sv/lbs_pkg.sv
sv/lbs_palette.sv
sv/lbs_lane.sv
sv/linear_blend_vertex_skinning.sv
bench/tb.sv
